// ----- sv/bijective_base6_encoder_unit_assert.svh -----
// assertion macros for the bijective base-6 encoder
`ifndef BIJECTIVE_BASE6_ENCODER_UNIT_ASSERT_SVH
`define BIJECTIVE_BASE6_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define BB6_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define BB6_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BB6_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BB6_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/bb6_pkg.sv -----
package bb6_pkg;

    // input value and digit buffer sizes
    localparam int VALUE_WIDTH = 64;
    localparam int DIGIT_SLOTS = 25;
    localparam int RADIX       = 6;

    localparam int DIGIT_W = 3;
    localparam int CHAR_W  = 6;
    localparam int CNT_W   = $clog2(DIGIT_SLOTS + 1);
    localparam int ADDR_W  = $clog2(DIGIT_SLOTS);

    // ascii codes of the result
    localparam logic [CHAR_W-1:0] CHAR_ONE  = CHAR_W'(49);
    localparam logic [CHAR_W-1:0] CHAR_SIX  = CHAR_W'(49 + RADIX - 1);
    localparam logic [CHAR_W-1:0] CHAR_NONE = CHAR_W'(0);

    // divide-by-six unit: one chunk of the working value per cycle
    localparam int CHUNK_W    = 16;
    localparam int NUM_CHUNKS = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int WORK_W     = NUM_CHUNKS * CHUNK_W;
    localparam int CHK_W      = $clog2(NUM_CHUNKS + 1);

    // reciprocal multiply: exact for every remainder/chunk pair
    localparam int X_W       = CHUNK_W + DIGIT_W;
    localparam int DIV_SHIFT = X_W + DIGIT_W;
    localparam int MAGIC_W   = DIV_SHIFT - 2;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'((1 << DIV_SHIFT) / RADIX + 1);

    // commands from the controller
    typedef struct packed {
        logic load_value;
        logic set_error;
        logic dec_step;
        logic div_step;
        logic store_digit;
        logic start_emit;
        logic read_digit;
        logic show_digit;
        logic next_digit;
    } bb6_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic value_nonpos;
        logic work_zero;
        logic chunk_done;
        logic out_taken;
        logic out_last;
    } bb6_sts_t;

endpackage

// ----- sv/bb6_ram.sv -----
module bb6_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 25
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/bb6_dpath.sv -----
module bb6_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [63:0]                 s_value,
    input  bb6_pkg::bb6_cmd_t                  cmd,
    output bb6_pkg::bb6_sts_t                  sts,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [5:0]                         m_digit_char,
    output logic                               m_last,
    output logic                               m_error
);

    logic [bb6_pkg::WORK_W-1:0]  work_reg, work_next;
    logic [bb6_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic [bb6_pkg::CHK_W-1:0]   chunk_cnt_reg, chunk_cnt_next;
    logic [bb6_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [bb6_pkg::ADDR_W-1:0]  idx_reg, idx_next;

    logic                        out_valid_reg;
    logic [bb6_pkg::CHAR_W-1:0]  out_char_reg;
    logic                        out_last_reg;
    logic                        out_error_reg;

    logic [bb6_pkg::VALUE_WIDTH-1:0] in_bits;
    logic                            in_nonpos;

    logic [bb6_pkg::X_W-1:0]             div_x;
    logic [bb6_pkg::X_W+bb6_pkg::MAGIC_W-1:0] div_prod;
    logic [bb6_pkg::CHUNK_W-1:0]         div_q;
    logic [bb6_pkg::X_W-1:0]             div_r_full;

    logic                        ram_we;
    logic [bb6_pkg::DIGIT_W-1:0] ram_rdata;

    // input value, sign taken from its top bit
    assign in_bits   = s_value[bb6_pkg::VALUE_WIDTH-1:0];
    assign in_nonpos = in_bits[bb6_pkg::VALUE_WIDTH-1] || (in_bits == '0);

    // one chunk of long division by six: remainder in front of the top chunk
    assign div_x      = {rem_reg, work_reg[bb6_pkg::WORK_W-1 -: bb6_pkg::CHUNK_W]};
    assign div_prod   = (bb6_pkg::X_W + bb6_pkg::MAGIC_W)'(div_x)
                      * (bb6_pkg::X_W + bb6_pkg::MAGIC_W)'(bb6_pkg::DIV_MAGIC);
    assign div_q      = div_prod[bb6_pkg::DIV_SHIFT +: bb6_pkg::CHUNK_W];
    assign div_r_full = div_x - (bb6_pkg::X_W'(div_q) << 2) - (bb6_pkg::X_W'(div_q) << 1);

    // working value, remainder and counters
    always_comb begin
        work_next      = work_reg;
        rem_next       = rem_reg;
        chunk_cnt_next = chunk_cnt_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        ram_we         = 1'b0;
        if (cmd.load_value) begin
            work_next  = bb6_pkg::WORK_W'(in_bits);
            count_next = '0;
        end
        if (cmd.set_error) begin
            work_next  = '0;
            count_next = '0;
        end
        if (cmd.dec_step) begin
            work_next      = work_reg - bb6_pkg::WORK_W'(1);
            rem_next       = '0;
            chunk_cnt_next = '0;
        end
        if (cmd.div_step) begin
            work_next      = (work_reg << bb6_pkg::CHUNK_W) | bb6_pkg::WORK_W'(div_q);
            rem_next       = div_r_full[bb6_pkg::DIGIT_W-1:0];
            chunk_cnt_next = chunk_cnt_reg + bb6_pkg::CHK_W'(1);
        end
        if (cmd.store_digit && (count_reg < bb6_pkg::CNT_W'(bb6_pkg::DIGIT_SLOTS))) begin
            ram_we     = 1'b1;
            count_next = count_reg + bb6_pkg::CNT_W'(1);
        end
        if (cmd.start_emit) begin
            idx_next = bb6_pkg::ADDR_W'(count_reg - bb6_pkg::CNT_W'(1));
        end
        if (cmd.next_digit) begin
            idx_next = idx_reg - bb6_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg      <= '0;
            rem_reg       <= '0;
            chunk_cnt_reg <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
        end else begin
            work_reg      <= work_next;
            rem_reg       <= rem_next;
            chunk_cnt_reg <= chunk_cnt_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
        end
    end

    // digit buffer, least significant digit first
    bb6_ram #(
        .WIDTH (bb6_pkg::DIGIT_W),
        .DEPTH (bb6_pkg::DIGIT_SLOTS)
    ) u_digit_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[bb6_pkg::ADDR_W-1:0]),
        .wdata (rem_reg),
        .re    (cmd.read_digit),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.set_error || cmd.show_digit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_error) begin
            out_char_reg  <= bb6_pkg::CHAR_NONE;
            out_last_reg  <= 1'b1;
            out_error_reg <= 1'b1;
        end else if (cmd.show_digit) begin
            out_char_reg  <= bb6_pkg::CHAR_ONE + bb6_pkg::CHAR_W'(ram_rdata);
            out_last_reg  <= (idx_reg == '0);
            out_error_reg <= 1'b0;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_digit_char = out_char_reg;
    assign m_last       = out_last_reg;
    assign m_error      = out_error_reg;

    // status to the controller
    assign sts.value_nonpos = in_nonpos;
    assign sts.work_zero    = (work_reg == '0);
    assign sts.chunk_done   = (chunk_cnt_reg == bb6_pkg::CHK_W'(bb6_pkg::NUM_CHUNKS - 1));
    assign sts.out_taken    = out_valid_reg && m_ready;
    assign sts.out_last     = out_last_reg;

endmodule

// ----- sv/bb6_ctrl.sv -----
module bb6_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bb6_pkg::bb6_sts_t  sts,
    output bb6_pkg::bb6_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_INDEX = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_SHOW  = 3'd6;
    localparam logic [2:0] ST_HOLD  = 3'd7;

    logic [2:0] state_reg, state_next;

    // sequencing of digit steps and emission
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (sts.value_nonpos) begin
                        cmd.set_error = 1'b1;
                        state_next    = ST_HOLD;
                    end else begin
                        cmd.load_value = 1'b1;
                        state_next     = ST_DEC;
                    end
                end
            end
            ST_DEC: begin
                cmd.dec_step = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.chunk_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store_digit = 1'b1;
                state_next      = sts.work_zero ? ST_INDEX : ST_DEC;
            end
            ST_INDEX: begin
                cmd.start_emit = 1'b1;
                state_next     = ST_READ;
            end
            ST_READ: begin
                cmd.read_digit = 1'b1;
                state_next     = ST_SHOW;
            end
            ST_SHOW: begin
                cmd.show_digit = 1'b1;
                state_next     = ST_HOLD;
            end
            ST_HOLD: begin
                if (sts.out_taken) begin
                    if (sts.out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_digit = 1'b1;
                        state_next     = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/bijective_base6_encoder_unit.sv -----
// Bijective base-6 encoder: takes one signed 64-bit value per transaction and returns
// its numeral as ASCII digits '1'..'6', most significant first, one result transaction
// per digit with m_last on the final one; a value of zero or less gives a single result
// with m_error and m_last set and digit code 0. One value is worked on at a time:
// s_ready is high only while the block is idle. A positive value is loaded, then each of
// its n digits takes a decrement step, four steps of the divide-by-six unit, which
// handles 16 bits per cycle, and a digit store step; after a setup step each digit is
// read from the buffer, shown and held until m_ready takes it;
// at most 25 digits are kept. An error result skips the digit steps.
`include "bijective_base6_encoder_unit_assert.svh"

module bijective_base6_encoder_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [63:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_digit_char,
    output logic               m_last,
    output logic               m_error
);

    bb6_pkg::bb6_cmd_t cmd;
    bb6_pkg::bb6_sts_t sts;

    // controller
    bb6_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath with divide unit, digit buffer and output register
    bb6_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_value      (s_value),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last       (m_last),
        .m_error      (m_error)
    );

    // checks
    `BB6_ASSERT_IMP(a_idle_no_result, aclk, aresetn, s_ready, !m_valid, "result pending while idle")
    `BB6_ASSERT_IMP(a_error_form, aclk, aresetn, m_valid && m_error, m_last && (m_digit_char == bb6_pkg::CHAR_NONE), "bad error result")
    `BB6_ASSERT_IMP(a_digit_range, aclk, aresetn, m_valid && !m_error, (m_digit_char >= bb6_pkg::CHAR_ONE) && (m_digit_char <= bb6_pkg::CHAR_SIX), "digit out of range")
    `BB6_ASSERT_NEXT(a_error_next, aclk, aresetn, s_valid && s_ready && (s_value[bb6_pkg::VALUE_WIDTH-1] || (s_value[bb6_pkg::VALUE_WIDTH-1:0] == '0)), m_valid && m_error, "missing error result")

endmodule

// ----- dv/tb_bijective_base6_encoder_unit.sv -----
`timescale 1ns / 100ps

module tb_bijective_base6_encoder_unit;
    import bb6_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 240;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              error;
    } digit_rec_t;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_THIRD, RDY_MOSTLY} ready_mode_t;

    // expected digit transactions, oldest first
    class numeral_scoreboard;
        digit_rec_t expected_digits[$];
        int         mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // work out the numeral of an accepted value
        function void note_value(logic signed [63:0] v);
            logic [63:0]        w;
            logic [63:0]        t;
            logic [DIGIT_W-1:0] lsd_first[$];
            digit_rec_t         rec;
            if (v <= 0) begin
                rec.digit_char = CHAR_NONE;
                rec.last       = 1'b1;
                rec.error      = 1'b1;
                expected_digits.push_back(rec);
                return;
            end
            w = v;
            while (w != 0) begin
                t = w - 64'd1;
                // only the least significant slots are kept
                if (lsd_first.size() < DIGIT_SLOTS)
                    lsd_first.push_back(DIGIT_W'(t % RADIX));
                w = t / RADIX;
            end
            // most significant digit goes out first
            for (int k = lsd_first.size() - 1; k >= 0; k--) begin
                rec.digit_char = CHAR_W'(CHAR_ONE + lsd_first[k]);
                rec.last       = (k == 0);
                rec.error      = 1'b0;
                expected_digits.push_back(rec);
            end
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_digit(logic [CHAR_W-1:0] dc, logic lst, logic err);
            digit_rec_t exp_rec;
            if (expected_digits.size() == 0) begin
                $error("unexpected result: digit_char %0d last %0b error %0b", dc, lst, err);
                mismatch_count++;
                return;
            end
            exp_rec = expected_digits.pop_front();
            if (dc !== exp_rec.digit_char) begin
                $error("digit_char mismatch: expected %0d, actual %0d", exp_rec.digit_char, dc);
                mismatch_count++;
            end
            if (lst !== exp_rec.last) begin
                $error("last mismatch: expected %0b, actual %0b", exp_rec.last, lst);
                mismatch_count++;
            end
            if (err !== exp_rec.error) begin
                $error("error mismatch: expected %0b, actual %0b", exp_rec.error, err);
                mismatch_count++;
            end
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [63:0] s_value = 64'sd0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [5:0]         m_digit_char;
    logic               m_last;
    logic               m_error;

    numeral_scoreboard sb = new();

    bijective_base6_encoder_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last       (m_last),
        .m_error      (m_error)
    );

    always #5 aclk = ~aclk;

    // smallest value whose numeral has n digits: 11...1 in base six
    function automatic logic signed [63:0] numeral_floor(int n);
        logic [63:0] acc;
        logic [63:0] pw;
        acc = 64'd0;
        pw  = 64'd1;
        for (int k = 0; k < n; k++) begin
            acc = acc + pw;
            pw  = pw * RADIX;
        end
        return $signed(acc);
    endfunction

    // random input value, weighted toward short numerals
    function automatic logic signed [63:0] pick_value();
        logic [63:0]        raw;
        logic signed [63:0] pick;
        int                 sel;
        int                 nbits;
        raw = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            pick = 64'($urandom_range(1, 300));
        end else if (sel < 60) begin
            nbits = $urandom_range(1, 63);
            raw   = raw & ((64'd1 << nbits) - 64'd1);
            pick  = (raw == 64'd0) ? 64'sd1 : $signed(raw);
        end else if (sel < 68) begin
            pick = $signed(raw | 64'h8000_0000_0000_0000);
        end else if (sel < 74) begin
            pick = -$signed(64'($urandom_range(0, 50)));
        end else if (sel < 87) begin
            // around the point where the numeral grows by a digit
            pick = numeral_floor($urandom_range(1, 25))
                   + $signed(64'($urandom_range(0, 2))) - 64'sd1;
        end else begin
            pick = $signed(raw);
        end
        return pick;
    endfunction

    // offer one value and wait for the transaction
    task automatic offer_value(input logic signed [63:0] v);
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_value(v);
    endtask

    // random gap between bursts, sometimes none
    task automatic idle_gap();
        int sel;
        int gap;
        sel = $urandom_range(0, 9);
        if (sel < 3) return;
        gap = (sel == 9) ? $urandom_range(60, 150) : $urandom_range(1, 25);
        s_valid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    // stop sending until every expected digit has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_digits.size() != 0) @(posedge aclk);
    endtask

    // result side: check each transaction, then vary m_ready
    int          digits_taken = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    int          mode_left    = 0;
    int          phase        = 0;
    ready_mode_t ready_mode   = RDY_ALWAYS;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_digit(m_digit_char, m_last, m_error);
            digits_taken++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && digits_taken >= HOLD_AFTER) begin
            // long hold-off so the block backs up into its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(10, 80);
            end
            mode_left--;
            phase++;
            case (ready_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                RDY_THIRD:  m_ready <= (phase % 3 == 0);
                default:    m_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // reset, directed values, then random bursts
    initial begin
        logic signed [63:0] directed_vals[$];
        int                 burst_left;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero, negatives, extremes, every single digit, digit-count boundaries
        directed_vals = {64'sd0, -64'sd1, $signed(64'h8000_0000_0000_0000),
                         $signed(64'h7FFF_FFFF_FFFF_FFFF), 64'sd1, 64'sd2, 64'sd3, 64'sd4,
                         64'sd5, 64'sd6, 64'sd7, 64'sd36, 64'sd42, 64'sd43, 64'sd258,
                         64'sd259, $signed(64'h5555_5555_5555_5555),
                         $signed(64'h2AAA_AAAA_AAAA_AAAA),
                         $signed(64'hFFFF_FFFF_FFFF_FFFE)};
        directed_vals.push_back(numeral_floor(DIGIT_SLOTS));
        directed_vals.push_back(numeral_floor(DIGIT_SLOTS) - 64'sd1);
        foreach (directed_vals[i])
            offer_value(directed_vals[i]);
        drain_results();

        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            if (burst_left == 0) begin
                idle_gap();
                burst_left = $urandom_range(1, 12);
            end
            offer_value(pick_value());
            burst_left--;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.expected_digits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
